### hdl/cht_pkg.sv
`default_nettype none

package cht_pkg;

  // Fixed field widths of the request and response beats.
  localparam int unsigned KIND_W   = 2;
  localparam int unsigned KEY_W    = 31;
  localparam int unsigned STATUS_W = 3;
  localparam int unsigned BUCKET_W = 4;

  // The bucket remainder is a reciprocal multiply step, then a
  // multiply back and a subtract.
  localparam int unsigned HASH_STEPS = 2;
  localparam int unsigned HASH_CNT_W = $clog2(HASH_STEPS);

  typedef enum logic [KIND_W-1:0] {
    KIND_INSERT = 2'd0,
    KIND_SEARCH = 2'd1,
    KIND_DELETE = 2'd2
  } kind_e;

  typedef enum logic [STATUS_W-1:0] {
    STATUS_INSERTED  = 3'd0,
    STATUS_DUPLICATE = 3'd1,
    STATUS_FOUND     = 3'd2,
    STATUS_NOT_FOUND = 3'd3,
    STATUS_FULL      = 3'd4
  } status_e;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic in_ready;
    logic load;
    logic clear_step;
    logic hash_step;
    logic walk_start;
    logic walk_step;
    logic commit;
  } cht_cmd_t;

  // Status from the datapath back to the controller.
  typedef struct packed {
    logic in_valid;
    logic clear_last;
    logic hash_last;
    logic walk_stop;
    logic out_free;
  } cht_sts_t;

endpackage

`default_nettype wire

### hdl/cht_if.sv
`default_nettype none

// Request channel: one operation and its key per beat.
interface cht_req_if;
  logic                        valid;
  logic                        ready;
  logic [cht_pkg::KIND_W-1:0]  kind;
  logic [cht_pkg::KEY_W-1:0]   key;

  modport source (output valid, output kind, output key, input ready);
  modport sink   (input valid, input kind, input key, output ready);
endinterface

// Response channel: one status and bucket per beat.
interface cht_rsp_if;
  logic                          valid;
  logic                          ready;
  logic [cht_pkg::STATUS_W-1:0]  status;
  logic [cht_pkg::BUCKET_W-1:0]  bucket;

  modport source (output valid, output status, output bucket, input ready);
  modport sink   (input valid, input status, input bucket, output ready);
endinterface

`default_nettype wire

### hdl/cht_ram.sv
`default_nettype none

module cht_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16
) (
  input  wire logic                                       clk_i,
  input  wire logic                                       we_i,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]                           wdata_i,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr_i,
  output logic      [WIDTH-1:0]                           rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  // One write port and one read port with registered read data.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

`default_nettype wire

### hdl/cht_ctrl.sv
`default_nettype none

module cht_ctrl (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire cht_pkg::cht_sts_t sts_i,
  output cht_pkg::cht_cmd_t      cmd_o
);

  typedef enum logic [6:0] {
    ST_CLEAR = 7'b0000001,
    ST_IDLE  = 7'b0000010,
    ST_HASH  = 7'b0000100,
    ST_HEAD  = 7'b0001000,
    ST_FIRST = 7'b0010000,
    ST_WALK  = 7'b0100000,
    ST_ACT   = 7'b1000000
  } state_e;

  state_e state_q, state_d;

  // Sequencing of one request: hash, head read, chain walk, update.
  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    unique case (state_q)
      ST_CLEAR: begin
        cmd_o.clear_step = 1'b1;
        if (sts_i.clear_last) state_d = ST_IDLE;
      end
      ST_IDLE: begin
        cmd_o.in_ready = 1'b1;
        if (sts_i.in_valid) begin
          cmd_o.load = 1'b1;
          state_d    = ST_HASH;
        end
      end
      ST_HASH: begin
        cmd_o.hash_step = 1'b1;
        if (sts_i.hash_last) state_d = ST_HEAD;
      end
      ST_HEAD: begin
        state_d = ST_FIRST;
      end
      ST_FIRST: begin
        cmd_o.walk_start = 1'b1;
        state_d          = ST_WALK;
      end
      ST_WALK: begin
        cmd_o.walk_step = 1'b1;
        if (sts_i.walk_stop) state_d = ST_ACT;
      end
      ST_ACT: begin
        if (sts_i.out_free) begin
          cmd_o.commit = 1'b1;
          state_d      = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_CLEAR;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_CLEAR;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

`default_nettype wire

### hdl/cht_dp.sv
`default_nettype none

module cht_dp #(
  parameter int unsigned NUM_BUCKETS = 16,
  parameter int unsigned NUM_NODES   = 64
) (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  input  wire logic                           req_valid_i,
  input  wire logic [cht_pkg::KIND_W-1:0]     req_kind_i,
  input  wire logic [cht_pkg::KEY_W-1:0]      req_key_i,
  input  wire logic                           rsp_ready_i,
  input  wire cht_pkg::cht_cmd_t              cmd_i,
  output cht_pkg::cht_sts_t                   sts_o,
  output logic                                rsp_valid_o,
  output logic [cht_pkg::STATUS_W-1:0]        rsp_status_o,
  output logic [cht_pkg::BUCKET_W-1:0]        rsp_bucket_o
);

  // Bucket index, node index and link widths.
  localparam int unsigned BW = (NUM_BUCKETS > 1) ? $clog2(NUM_BUCKETS) : 1;
  localparam int unsigned AW = (NUM_NODES > 1) ? $clog2(NUM_NODES) : 1;
  localparam int unsigned LW = $clog2(NUM_NODES + 1);
  localparam int unsigned NW = cht_pkg::KEY_W + LW;

  // Reciprocal of the bucket count, exact for every key below 2**KEY_W.
  localparam int unsigned DIV_SH = cht_pkg::KEY_W + $clog2(NUM_BUCKETS);
  localparam longint unsigned RECIP_FULL =
    ((64'd1 << DIV_SH) + 64'(NUM_BUCKETS) - 64'd1) / 64'(NUM_BUCKETS);
  localparam logic [31:0] RECIP = 32'(RECIP_FULL);
  localparam logic [cht_pkg::KEY_W-1:0] BUCKETS_K = cht_pkg::KEY_W'(NUM_BUCKETS);

  localparam logic [BW-1:0] LAST_BKT   = BW'(NUM_BUCKETS - 1);
  localparam logic [LW-1:0] NULL_LINK  = LW'(NUM_NODES);
  localparam logic [cht_pkg::HASH_CNT_W-1:0] LAST_HASH =
    cht_pkg::HASH_CNT_W'(cht_pkg::HASH_STEPS - 1);

  // Request registers.
  logic [cht_pkg::KIND_W-1:0]     kind_q;
  logic [cht_pkg::KEY_W-1:0]      key_q;
  logic [cht_pkg::KEY_W-1:0]      quot_q, quot_d;
  logic [BW-1:0]                  rem_q, rem_d;
  logic [cht_pkg::HASH_CNT_W-1:0] hcnt_q;
  logic [BW-1:0]                  clr_cnt_q;

  // Remainder datapath.
  logic [cht_pkg::KEY_W+31:0]     quot_prod;
  logic [cht_pkg::KEY_W-1:0]      quot_back, rem_full;

  // Walk registers.
  logic [LW-1:0]                  cur_q, prev_q, head_q, hit_next_q, steps_q;
  logic [cht_pkg::KEY_W-1:0]      prev_key_q;
  logic                           prev_valid_q, hit_q;

  // Allocation state: a stack of freed nodes and a count of never-used nodes.
  logic [LW-1:0]                  sp_q, fresh_q;

  // Response register.
  logic                           out_valid_q;
  logic [cht_pkg::STATUS_W-1:0]   out_status_q;
  logic [BW+3:0]                  out_bkt_q;

  // Memory ports.
  logic                           head_we, node_we, stk_we;
  logic [BW-1:0]                  head_waddr;
  logic [LW-1:0]                  head_wdata, head_rdata;
  logic [AW-1:0]                  node_waddr, node_raddr, stk_raddr;
  logic [NW-1:0]                  node_wdata, node_rdata;
  logic [AW-1:0]                  stk_rdata;

  logic [cht_pkg::KEY_W-1:0]      rd_key;
  logic [LW-1:0]                  rd_next;
  logic                           walk_live, walk_match;
  logic                           alloc_pop, alloc_ok;
  logic [AW-1:0]                  alloc_node;
  cht_pkg::status_e               status_d;
  logic                           do_insert, do_delete;

  // Remainder: the quotient from a reciprocal multiply, then key minus
  // quotient times the bucket count in the following cycle.
  assign quot_prod = {{32{1'b0}}, key_q} * {{cht_pkg::KEY_W{1'b0}}, RECIP};
  assign quot_d    = cht_pkg::KEY_W'(quot_prod >> DIV_SH);
  assign quot_back = quot_q * BUCKETS_K;
  assign rem_full  = key_q - quot_back;
  assign rem_d     = rem_full[BW-1:0];

  // Chain walk compare on the node just read.
  assign rd_key     = node_rdata[NW-1:LW];
  assign rd_next    = node_rdata[LW-1:0];
  assign walk_live  = (cur_q < NULL_LINK) && (steps_q < NULL_LINK);
  assign walk_match = walk_live && (rd_key == key_q);

  // Node allocation: reuse a freed node first, then take a fresh one.
  assign alloc_pop  = (sp_q != '0);
  assign alloc_ok   = alloc_pop || (fresh_q < NULL_LINK);
  assign alloc_node = alloc_pop ? stk_rdata : fresh_q[AW-1:0];
  assign stk_raddr  = AW'(sp_q - LW'(1));

  // Outcome of the request once the walk has ended.
  always_comb begin
    status_d  = cht_pkg::STATUS_NOT_FOUND;
    do_insert = 1'b0;
    do_delete = 1'b0;
    unique case (kind_q)
      cht_pkg::KIND_INSERT: begin
        if (hit_q) begin
          status_d = cht_pkg::STATUS_DUPLICATE;
        end else if (alloc_ok) begin
          status_d  = cht_pkg::STATUS_INSERTED;
          do_insert = 1'b1;
        end else begin
          status_d = cht_pkg::STATUS_FULL;
        end
      end
      cht_pkg::KIND_SEARCH: begin
        status_d = hit_q ? cht_pkg::STATUS_FOUND : cht_pkg::STATUS_NOT_FOUND;
      end
      cht_pkg::KIND_DELETE: begin
        if (hit_q) begin
          status_d  = cht_pkg::STATUS_FOUND;
          do_delete = 1'b1;
        end
      end
      default: begin
        status_d = cht_pkg::STATUS_NOT_FOUND;
      end
    endcase
  end

  // Head table writes: clearing pass, new head on insert, unlink at head.
  always_comb begin
    head_we    = 1'b0;
    head_waddr = rem_q[BW-1:0];
    head_wdata = NULL_LINK;
    if (cmd_i.clear_step) begin
      head_we    = 1'b1;
      head_waddr = clr_cnt_q;
    end else if (cmd_i.commit && do_insert) begin
      head_we    = 1'b1;
      head_wdata = LW'(alloc_node);
    end else if (cmd_i.commit && do_delete && !prev_valid_q) begin
      head_we    = 1'b1;
      head_wdata = hit_next_q;
    end
  end

  // Node writes: new node on insert, relink of the predecessor on delete.
  always_comb begin
    node_we    = 1'b0;
    node_waddr = alloc_node;
    node_wdata = {key_q, head_q};
    if (cmd_i.commit && do_insert) begin
      node_we = 1'b1;
    end else if (cmd_i.commit && do_delete && prev_valid_q) begin
      node_we    = 1'b1;
      node_waddr = prev_q[AW-1:0];
      node_wdata = {prev_key_q, hit_next_q};
    end
  end

  assign node_raddr = cmd_i.walk_start ? head_rdata[AW-1:0] : rd_next[AW-1:0];
  assign stk_we     = cmd_i.commit && do_delete;

  cht_ram #(.WIDTH(LW), .DEPTH(NUM_BUCKETS)) u_head_ram (
    .clk_i   (clk_i),
    .we_i    (head_we),
    .waddr_i (head_waddr),
    .wdata_i (head_wdata),
    .raddr_i (rem_q[BW-1:0]),
    .rdata_o (head_rdata)
  );

  cht_ram #(.WIDTH(NW), .DEPTH(NUM_NODES)) u_node_ram (
    .clk_i   (clk_i),
    .we_i    (node_we),
    .waddr_i (node_waddr),
    .wdata_i (node_wdata),
    .raddr_i (node_raddr),
    .rdata_o (node_rdata)
  );

  cht_ram #(.WIDTH(AW), .DEPTH(NUM_NODES)) u_free_stack (
    .clk_i   (clk_i),
    .we_i    (stk_we),
    .waddr_i (sp_q[AW-1:0]),
    .wdata_i (cur_q[AW-1:0]),
    .raddr_i (stk_raddr),
    .rdata_o (stk_rdata)
  );

  // Request capture, remainder steps, chain walk and response data registers.
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      kind_q <= req_kind_i;
      key_q  <= req_key_i;
      rem_q  <= '0;
    end else if (cmd_i.hash_step) begin
      if (hcnt_q == LAST_HASH) begin
        rem_q <= rem_d;
      end else begin
        quot_q <= quot_d;
      end
    end
    if (cmd_i.walk_start) begin
      cur_q        <= head_rdata;
      head_q       <= head_rdata;
      steps_q      <= '0;
      prev_valid_q <= 1'b0;
      hit_q        <= 1'b0;
    end else if (cmd_i.walk_step) begin
      if (walk_match) begin
        hit_q      <= 1'b1;
        hit_next_q <= rd_next;
      end else if (walk_live) begin
        prev_q       <= cur_q;
        prev_key_q   <= rd_key;
        prev_valid_q <= 1'b1;
        cur_q        <= rd_next;
        steps_q      <= steps_q + LW'(1);
      end
    end
    if (cmd_i.commit) begin
      out_status_q <= status_d;
      out_bkt_q    <= {4'd0, rem_q[BW-1:0]};
    end
  end

  // Control counters, allocation state and response valid.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hcnt_q      <= '0;
      clr_cnt_q   <= '0;
      sp_q        <= '0;
      fresh_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (cmd_i.load) begin
        hcnt_q <= '0;
      end else if (cmd_i.hash_step) begin
        hcnt_q <= hcnt_q + cht_pkg::HASH_CNT_W'(1);
      end
      if (cmd_i.clear_step) begin
        clr_cnt_q <= clr_cnt_q + BW'(1);
      end
      if (cmd_i.commit && do_insert) begin
        if (alloc_pop) begin
          sp_q <= sp_q - LW'(1);
        end else begin
          fresh_q <= fresh_q + LW'(1);
        end
      end else if (stk_we) begin
        sp_q <= sp_q + LW'(1);
      end
      if (cmd_i.commit) begin
        out_valid_q <= 1'b1;
      end else if (rsp_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  assign sts_o.in_valid   = req_valid_i;
  assign sts_o.clear_last = (clr_cnt_q == LAST_BKT);
  assign sts_o.hash_last  = (hcnt_q == LAST_HASH);
  assign sts_o.walk_stop  = walk_match || !walk_live;
  assign sts_o.out_free   = !out_valid_q || rsp_ready_i;

  assign rsp_valid_o  = out_valid_q;
  assign rsp_status_o = out_status_q;
  assign rsp_bucket_o = out_bkt_q[cht_pkg::BUCKET_W-1:0];

endmodule

`default_nettype wire

### hdl/chained_hash_table_top.sv
// Hash set of 31-bit keys with separate chaining over a fixed node pool.
// Request beats on req_i carry an operation (insert, search, delete) and a
// key; each request yields exactly one response beat on rsp_o with a status
// and the key's bucket (key modulo NUM_BUCKETS, low four bits).
// One request is in flight at a time. After acceptance a request passes
// through the bucket remainder unit (a reciprocal multiply, then a multiply
// back and a subtract), a read of the chain head, a fetch of its first
// node, and the chain walk, which reads one node per cycle from the node
// memory's single read port, and then commits to the response register.
// After reset the head table is cleared in a pass over all NUM_BUCKETS
// entries, during which req_i.ready stays low; all nodes start free.
// The response sits in an output register. The next request is accepted
// while that response waits; if rsp_o is still stalled when the next
// result is ready, the block holds it and commits no state change until
// the register frees up.
`default_nettype none

module chained_hash_table_top #(
  parameter int unsigned NUM_BUCKETS = 16,
  parameter int unsigned NUM_NODES   = 64
) (
  input  wire logic   clk_i,
  input  wire logic   rst_ni,
  cht_req_if.sink     req_i,
  cht_rsp_if.source   rsp_o
);

  cht_pkg::cht_cmd_t cmd;
  cht_pkg::cht_sts_t sts;

  cht_ctrl u_ctrl (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .sts_i  (sts),
    .cmd_o  (cmd)
  );

  cht_dp #(
    .NUM_BUCKETS (NUM_BUCKETS),
    .NUM_NODES   (NUM_NODES)
  ) u_dp (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .req_valid_i  (req_i.valid),
    .req_kind_i   (req_i.kind),
    .req_key_i    (req_i.key),
    .rsp_ready_i  (rsp_o.ready),
    .cmd_i        (cmd),
    .sts_o        (sts),
    .rsp_valid_o  (rsp_o.valid),
    .rsp_status_o (rsp_o.status),
    .rsp_bucket_o (rsp_o.bucket)
  );

  assign req_i.ready = cmd.in_ready;

  // A new response only appears after a commit.
  a_rsp_from_commit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(rsp_o.valid) |-> $past(cmd.commit))
    else $error("response beat without a commit");

  // A commit never overwrites a response that is still stalled.
  a_commit_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.commit |-> (!rsp_o.valid || rsp_o.ready))
    else $error("commit while the response register is busy");

  // Once a request beat is taken, no other is taken until it is done.
  a_one_in_flight: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (req_i.valid && req_i.ready) |=> !req_i.ready)
    else $error("request accepted while another is in flight");

endmodule

`default_nettype wire

### tb/sv/chained_hash_table_top_tb.sv
`default_nettype none

module chained_hash_table_top_tb;
  import cht_pkg::*;

  localparam int unsigned NUM_BUCKETS = 16;
  localparam int unsigned NUM_NODES   = 64;
  localparam int unsigned LINK_W      = $clog2(NUM_NODES + 1);
  localparam int unsigned NULL_LINK   = NUM_NODES;

  // The fourth operation code is not defined by the package.
  localparam logic [KIND_W-1:0] KIND_UNUSED = 2'd3;

  // Key set for the random part: the first half shares one bucket.
  localparam int unsigned      POOL_KEYS  = 128;
  localparam logic [3:0]       HOT_BUCKET = 4'h9;
  localparam int unsigned      HOLD_CYCLES = 400;

  typedef enum int {
    MODE_FILL,
    MODE_MIX,
    MODE_DRAIN,
    MODE_NOISE
  } round_mode_e;

  typedef struct packed {
    status_e              status;
    logic [BUCKET_W-1:0]  bucket;
  } lookup_rsp_t;

  typedef struct packed {
    logic [KIND_W-1:0]  kind;
    logic [KEY_W-1:0]   key;
    logic               typed;
    lookup_rsp_t        rsp;
  } dir_row_t;

  logic clk_i;
  logic rst_ni;

  cht_req_if req ();
  cht_rsp_if rsp ();

  chained_hash_table_top #(
    .NUM_BUCKETS(NUM_BUCKETS),
    .NUM_NODES  (NUM_NODES)
  ) dut (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .req_i (req),
    .rsp_o (rsp)
  );

  // Shadow copy of the hash set.
  logic [LINK_W-1:0] chain_first [NUM_BUCKETS];
  logic [KEY_W-1:0]  node_key    [NUM_NODES];
  logic [LINK_W-1:0] node_link   [NUM_NODES];
  logic              node_idle   [NUM_NODES];

  lookup_rsp_t      pending_rsp [$];
  logic [KEY_W-1:0] pool_key [POOL_KEYS];

  int src_idle_pct;
  int snk_stall_pct;
  int hold_reqs;
  int hold_seen;
  int hold_left;
  int fail_cnt = 0;
  int items_sent;
  int rsp_checked = 0;
  int status_seen [5] = '{default: 0};

  // Directed requests; rows with typed clear (bucket 0 chain) use the shadow set.
  dir_row_t dir_rows [21] = '{
    '{KIND_SEARCH, 31'd0,          1'b1, '{STATUS_NOT_FOUND, 4'd0}},
    '{KIND_DELETE, 31'h7FFF_FFFF,  1'b1, '{STATUS_NOT_FOUND, 4'd15}},
    '{KIND_INSERT, 31'd0,          1'b1, '{STATUS_INSERTED,  4'd0}},
    '{KIND_INSERT, 31'd0,          1'b1, '{STATUS_DUPLICATE, 4'd0}},
    '{KIND_INSERT, 31'h7FFF_FFFF,  1'b1, '{STATUS_INSERTED,  4'd15}},
    '{KIND_SEARCH, 31'h7FFF_FFFF,  1'b1, '{STATUS_FOUND,     4'd15}},
    '{KIND_INSERT, 31'd16,         1'b0, '{STATUS_INSERTED,  4'd0}},
    '{KIND_INSERT, 31'd32,         1'b0, '{STATUS_INSERTED,  4'd0}},
    '{KIND_SEARCH, 31'd0,          1'b0, '{STATUS_INSERTED,  4'd0}},
    '{KIND_SEARCH, 31'd48,         1'b0, '{STATUS_INSERTED,  4'd0}},
    '{KIND_DELETE, 31'd16,         1'b0, '{STATUS_INSERTED,  4'd0}},
    '{KIND_DELETE, 31'd32,         1'b0, '{STATUS_INSERTED,  4'd0}},
    '{KIND_DELETE, 31'd0,          1'b0, '{STATUS_INSERTED,  4'd0}},
    '{KIND_SEARCH, 31'd0,          1'b1, '{STATUS_NOT_FOUND, 4'd0}},
    '{KIND_DELETE, 31'd0,          1'b1, '{STATUS_NOT_FOUND, 4'd0}},
    '{KIND_UNUSED, 31'd5,          1'b1, '{STATUS_NOT_FOUND, 4'd5}},
    '{KIND_UNUSED, 31'h7FFF_FFFF,  1'b1, '{STATUS_NOT_FOUND, 4'd15}},
    '{KIND_INSERT, 31'h2AAA_AAAA,  1'b1, '{STATUS_INSERTED,  4'd10}},
    '{KIND_INSERT, 31'h5555_5555,  1'b1, '{STATUS_INSERTED,  4'd5}},
    '{KIND_DELETE, 31'h7FFF_FFFF,  1'b1, '{STATUS_FOUND,     4'd15}},
    '{KIND_SEARCH, 31'h5555_5555,  1'b1, '{STATUS_FOUND,     4'd5}}
  };

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // Apply one request to the shadow set and return the response it must give.
  function automatic lookup_rsp_t hash_set_apply(input logic [KIND_W-1:0] kind,
                                                 input logic [KEY_W-1:0] key);
    lookup_rsp_t r;
    int unsigned b;
    int cur;
    int prev;
    int hit;
    int steps;
    int slot;
    b     = key % NUM_BUCKETS;
    cur   = chain_first[b];
    prev  = NULL_LINK;
    hit   = NULL_LINK;
    steps = 0;
    // A walk ends on a hit, a link outside the pool or after one step per node.
    while (cur < NUM_NODES && steps < NUM_NODES && hit == NULL_LINK) begin
      if (node_key[cur] == key) begin
        hit = cur;
      end else begin
        prev = cur;
        cur  = node_link[cur];
        steps++;
      end
    end
    r.bucket = b[BUCKET_W-1:0];
    r.status = STATUS_NOT_FOUND;
    case (kind)
      KIND_INSERT: begin
        if (hit != NULL_LINK) begin
          r.status = STATUS_DUPLICATE;
        end else begin
          slot = NULL_LINK;
          for (int i = NUM_NODES - 1; i >= 0; i--) begin
            if (node_idle[i]) slot = i;
          end
          if (slot == NULL_LINK) begin
            r.status = STATUS_FULL;
          end else begin
            node_idle[slot]  = 1'b0;
            node_key[slot]   = key;
            node_link[slot]  = chain_first[b];
            chain_first[b]   = slot[LINK_W-1:0];
            r.status         = STATUS_INSERTED;
          end
        end
      end
      KIND_SEARCH: begin
        if (hit != NULL_LINK) r.status = STATUS_FOUND;
      end
      KIND_DELETE: begin
        if (hit != NULL_LINK) begin
          if (prev != NULL_LINK) node_link[prev] = node_link[hit];
          else chain_first[b] = node_link[hit];
          node_link[hit] = NULL_LINK[LINK_W-1:0];
          node_idle[hit] = 1'b1;
          r.status = STATUS_FOUND;
        end
      end
      default: begin
        // The unused code leaves the set alone and answers not found.
      end
    endcase
    return r;
  endfunction

  function automatic logic [KEY_W-1:0] rand_key();
    logic [31:0] w;
    w = $urandom;
    return w[KEY_W-1:0];
  endfunction

  // Offer one request beat, optionally after an idle gap, and log its response.
  task automatic send_req(input logic [KIND_W-1:0] kind, input logic [KEY_W-1:0] key,
                          input logic typed, input lookup_rsp_t typed_rsp);
    int gap;
    lookup_rsp_t pred;
    gap = 0;
    while (gap < 30 && $urandom_range(99) < src_idle_pct) gap++;
    if (gap > 0) begin
      req.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    req.valid <= 1'b1;
    req.kind  <= kind;
    req.key   <= key;
    do @(posedge clk_i); while (req.ready !== 1'b1);
    pred = hash_set_apply(kind, key);
    pending_rsp.push_back(typed ? typed_rsp : pred);
    items_sent++;
  endtask

  // Stop offering and wait until every response has come back.
  task automatic wait_drain();
    req.valid <= 1'b0;
    do @(posedge clk_i); while (pending_rsp.size() != 0);
  endtask

  // One round of random requests shaped by its mode.
  task automatic run_round(input round_mode_e mode, input int n);
    int base;
    int r;
    logic [KIND_W-1:0] kind;
    logic [KEY_W-1:0]  key;
    base = $urandom_range(POOL_KEYS - 1);
    for (int i = 0; i < n; i++) begin
      r = $urandom_range(99);
      case (mode)
        MODE_FILL: begin
          // Walk distinct keys so the pool runs dry.
          key  = pool_key[(base + i) % POOL_KEYS];
          kind = (r < 90) ? KIND_INSERT : KIND_SEARCH;
        end
        MODE_DRAIN: begin
          key  = pool_key[(base + i) % POOL_KEYS];
          kind = (r < 80) ? KIND_DELETE : KIND_SEARCH;
        end
        MODE_MIX: begin
          key = pool_key[$urandom_range(POOL_KEYS - 1)];
          if (r < 32)      kind = KIND_INSERT;
          else if (r < 64) kind = KIND_SEARCH;
          else if (r < 96) kind = KIND_DELETE;
          else             kind = KIND_UNUSED;
        end
        default: begin
          key  = ($urandom_range(1) == 0) ? rand_key() : pool_key[$urandom_range(POOL_KEYS - 1)];
          kind = KIND_W'($urandom_range(3));
        end
      endcase
      send_req(kind, key, 1'b0, '0);
    end
  endtask

  // Response side: check each accepted beat, then choose ready for the next cycle.
  always @(posedge clk_i) begin
    lookup_rsp_t want;
    if (rst_ni === 1'b1 && rsp.valid === 1'b1 && rsp.ready === 1'b1) begin
      if (pending_rsp.size() == 0) begin
        $error("response beat with no request outstanding: status %0d bucket %0d",
               rsp.status, rsp.bucket);
        fail_cnt++;
      end else begin
        want = pending_rsp.pop_front();
        rsp_checked++;
        if (rsp.status !== want.status) begin
          $error("status: expected %0d, got %0d", want.status, rsp.status);
          fail_cnt++;
        end
        if (rsp.bucket !== want.bucket) begin
          $error("bucket: expected %0d, got %0d", want.bucket, rsp.bucket);
          fail_cnt++;
        end
        if (rsp.status < 5) status_seen[rsp.status]++;
      end
    end

    if (rst_ni !== 1'b1) begin
      hold_seen <= 0;
      hold_left <= 0;
      rsp.ready <= 1'b0;
    end else if (hold_seen != hold_reqs) begin
      hold_seen <= hold_reqs;
      hold_left <= HOLD_CYCLES;
      rsp.ready <= 1'b0;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
      rsp.ready <= 1'b0;
    end else begin
      rsp.ready <= ($urandom_range(99) >= snk_stall_pct);
    end
  end

  // Stimulus and end of run.
  initial begin
    round_mode_e mode;
    int phase;
    int n;
    rst_ni        = 1'b0;
    req.valid     = 1'b0;
    req.kind      = KIND_INSERT;
    req.key       = '0;
    src_idle_pct  = 0;
    snk_stall_pct = 0;
    hold_reqs     = 0;
    items_sent    = 0;
    foreach (chain_first[i]) chain_first[i] = NULL_LINK[LINK_W-1:0];
    foreach (node_key[i]) begin
      node_key[i]  = '0;
      node_link[i] = NULL_LINK[LINK_W-1:0];
      node_idle[i] = 1'b1;
    end
    foreach (pool_key[i]) begin
      pool_key[i] = rand_key();
      if (i < POOL_KEYS / 2) pool_key[i][3:0] = HOT_BUCKET;
    end

    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Directed requests back to back.
    foreach (dir_rows[i]) begin
      send_req(dir_rows[i].kind, dir_rows[i].key, dir_rows[i].typed, dir_rows[i].rsp);
    end
    wait_drain();

    // Random rounds: every mode under every idle/stall mix.
    for (int round = 0; round < 24; round++) begin
      mode  = round_mode_e'(round % 4);
      phase = (round / 4) % 4;
      case (phase)
        0: begin src_idle_pct = 0;  snk_stall_pct = 0;  end
        1: begin src_idle_pct = 65; snk_stall_pct = 0;  end
        2: begin src_idle_pct = 0;  snk_stall_pct = 65; end
        default: begin src_idle_pct = 35; snk_stall_pct = 35; end
      endcase
      // Twice the response side holds off while requests keep coming.
      if (round == 4 || round == 13) hold_reqs <= hold_reqs + 1;
      case (mode)
        MODE_FILL, MODE_DRAIN: n = 96;
        MODE_MIX:              n = 60;
        default:               n = 40;
      endcase
      run_round(mode, n);
      wait_drain();
    end

    repeat (100) @(posedge clk_i);
    $display("Checked %0d responses to %0d requests under four idle/stall mixes.",
             rsp_checked, items_sent);
    $display("Seen: %0d inserted, %0d duplicate, %0d found, %0d not found, %0d pool full.",
             status_seen[0], status_seen[1], status_seen[2], status_seen[3], status_seen[4]);
    if (fail_cnt == 0 && pending_rsp.size() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

  // Watchdog for a hung handshake.
  initial begin
    #10_000_000;
    $display("FAILURE");
    $finish;
  end

endmodule

`default_nettype wire
